### src/duplicate_address_resolver_macros.svh
// assertion macros for the duplicate address resolver
// used by the top level only; expects clk and arst_n in scope
`ifndef DUPLICATE_ADDRESS_RESOLVER_MACROS_SVH
`define DUPLICATE_ADDRESS_RESOLVER_MACROS_SVH

// property that holds at every clock edge outside reset
`define DAR_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// same-cycle implication
`define DAR_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### src/dar_pkg.sv
// shared types, codes and constants of the duplicate address resolver
// no dependencies; used by the interfaces, the cells, the controller and the top level
`default_nettype none

package dar_pkg;

	localparam int MAX_NODES_DEF = 64;

	localparam int ADDR_W   = 16;
	localparam int MAC_W    = 48;
	localparam int MACX_W   = 49;
	localparam int STATUS_W = 2;
	localparam int IDXO_W   = 6;
	localparam int ENTRY_W  = 3 * ADDR_W + MAC_W;

	localparam int MIN_NODES = 2;
	localparam logic [ADDR_W-1:0] NO_ADDR = 16'hCCCC;

	// result status codes
	localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_REPROG = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FEW    = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_OVF    = 2'd3;

	// packet operations along the cell chain
	localparam logic [1:0] OP_FETCH = 2'd0;
	localparam logic [1:0] OP_ADDR  = 2'd1;
	localparam logic [1:0] OP_MAC   = 2'd2;

	typedef struct packed {
		logic [ADDR_W-1:0] na;
		logic [ADDR_W-1:0] ga;
		logic [ADDR_W-1:0] di;
		logic [MAC_W-1:0]  mac;
	} entry_t;

	typedef struct packed {
		logic [1:0]         op;
		logic               hit;
		logic [ENTRY_W-1:0] data;
	} pkt_body_t;

	typedef struct packed {
		logic      vld;
		pkt_body_t body;
	} pkt_t;

	// what one cell hands to the next
	typedef struct packed {
		logic filled;
		logic tok;
		pkt_t pkt;
	} link_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic   load;
		logic   clear;
		logic   advance;
		entry_t entry;
	} cmd_t;

endpackage

`default_nettype wire

### src/dar_if.sv
// input and output channel interfaces of the duplicate address resolver
// depends on dar_pkg for the field widths
`default_nettype none

interface dar_in_if;
	logic                         valid;
	logic                         ready;
	logic [dar_pkg::ADDR_W-1:0]   node_addr;
	logic [dar_pkg::ADDR_W-1:0]   group_addr;
	logic [dar_pkg::ADDR_W-1:0]   diag_id;
	logic [dar_pkg::MAC_W-1:0]    mac_addr;
	logic                         last_node;

	modport source (output valid, output node_addr, output group_addr, output diag_id,
		output mac_addr, output last_node, input ready);
	modport sink (input valid, input node_addr, input group_addr, input diag_id,
		input mac_addr, input last_node, output ready);
endinterface

interface dar_out_if;
	logic                         valid;
	logic                         ready;
	logic [dar_pkg::STATUS_W-1:0] status;
	logic [dar_pkg::IDXO_W-1:0]   node_index;
	logic [dar_pkg::ADDR_W-1:0]   new_node_addr;
	logic [dar_pkg::ADDR_W-1:0]   new_group_addr;
	logic [dar_pkg::MAC_W-1:0]    new_mac_addr;

	modport source (output valid, output status, output node_index, output new_node_addr,
		output new_group_addr, output new_mac_addr, input ready);
	modport sink (input valid, input status, input node_index, input new_node_addr,
		input new_group_addr, input new_mac_addr, output ready);
endinterface

`default_nettype wire

### src/dar_cell.sv
// one cell of the node chain: holds one node entry and forwards a packet per cycle
// depends on dar_pkg
`default_nettype none

module dar_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  dar_pkg::cmd_t  cmd,
	input  dar_pkg::link_t prev,
	output dar_pkg::link_t link
);

	logic              filled_q;
	logic              tok_q;
	logic              vld_q;
	dar_pkg::entry_t   entry_q;
	dar_pkg::pkt_body_t body_q;
	dar_pkg::pkt_body_t body_nxt;

	// compare against the stored entry, the scan owner never compares
	always_comb begin
		body_nxt = prev.pkt.body;
		if (prev.pkt.vld) begin
			unique case (prev.pkt.body.op)
				dar_pkg::OP_FETCH: begin
					if (tok_q) begin
						body_nxt.data = entry_q;
					end
				end
				dar_pkg::OP_ADDR: begin
					if (filled_q && !tok_q &&
					    prev.pkt.body.data[dar_pkg::ADDR_W-1:0] == entry_q.na) begin
						body_nxt.hit = 1'b1;
					end
				end
				dar_pkg::OP_MAC: begin
					if (filled_q && !tok_q &&
					    prev.pkt.body.data[dar_pkg::MACX_W-1:0] == {1'b0, entry_q.mac}) begin
						body_nxt.hit = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= 1'b0;
			tok_q    <= 1'b0;
			vld_q    <= 1'b0;
		end else begin
			vld_q <= prev.pkt.vld;
			if (cmd.clear) begin
				filled_q <= 1'b0;
				tok_q    <= 1'b0;
			end else begin
				if (cmd.load && !filled_q && prev.filled) begin
					filled_q <= 1'b1;
				end
				if (cmd.advance) begin
					tok_q <= prev.tok;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		body_q <= body_nxt;
		if (cmd.load && !filled_q && prev.filled) begin
			entry_q <= cmd.entry;
		end
	end

	always_comb begin
		link.filled   = filled_q;
		link.tok      = tok_q;
		link.pkt.vld  = vld_q;
		link.pkt.body = body_q;
	end

endmodule

`default_nettype wire

### src/dar_ctrl.sv
// controller: loads items into the cell chain, runs the scan and the searches,
// and holds the result register; depends on dar_pkg and the channel interfaces
`default_nettype none

module dar_ctrl #(
	parameter int MAX_NODES = dar_pkg::MAX_NODES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	dar_in_if.sink         in_ch,
	dar_out_if.source      out_ch,
	output dar_pkg::cmd_t  cmd,
	output dar_pkg::link_t head,
	input  dar_pkg::link_t tail
);

	localparam int IDX_W = $clog2(MAX_NODES);
	localparam int CNT_W = IDX_W + 1;
	localparam int EW    = dar_pkg::ENTRY_W;
	localparam int AW    = dar_pkg::ADDR_W;
	localparam int XW    = dar_pkg::MACX_W;
	localparam int IOW   = dar_pkg::IDXO_W;

	localparam logic [3:0] S_LOAD   = 4'd0;
	localparam logic [3:0] S_START  = 4'd1;
	localparam logic [3:0] S_ADV    = 4'd2;
	localparam logic [3:0] S_FETCH  = 4'd3;
	localparam logic [3:0] S_WFETCH = 4'd4;
	localparam logic [3:0] S_CHKA   = 4'd5;
	localparam logic [3:0] S_CHKM   = 4'd6;
	localparam logic [3:0] S_WCHK   = 4'd7;
	localparam logic [3:0] S_DEC    = 4'd8;
	localparam logic [3:0] S_ASRCH  = 4'd9;
	localparam logic [3:0] S_MSRCH  = 4'd10;
	localparam logic [3:0] S_EMIT   = 4'd11;

	logic [3:0]                   state_q;
	logic [CNT_W-1:0]             count_q;
	logic                         ovf_q;
	logic [IDX_W-1:0]             idx_q;
	logic                         found_q;
	logic [CNT_W-1:0]             inflight_q;
	logic                         out_vld_q;

	dar_pkg::entry_t              ent_q;
	logic                         a_hit_q;
	logic                         m_hit_q;
	logic [XW-1:0]                cand_q;
	logic [AW-1:0]                new_na_q;
	logic [XW-1:0]                new_mac_q;
	logic [dar_pkg::STATUS_W-1:0] res_status_q;

	logic [dar_pkg::STATUS_W-1:0] o_status_q;
	logic [IOW-1:0]               o_idx_q;
	logic [AW-1:0]                o_na_q;
	logic [AW-1:0]                o_ga_q;
	logic [dar_pkg::MAC_W-1:0]    o_mac_q;

	logic                         acc;
	logic                         emit_go;
	logic                         srch_done;
	logic                         first_free;
	dar_pkg::pkt_t                inj;
	logic [CNT_W-1:0]             idx_nx;
	logic [IDX_W+IOW-1:0]         idx_wide;
	logic [AW-1:0]                addr_start;

	assign in_ch.ready = (state_q == S_LOAD);
	assign acc         = in_ch.valid && in_ch.ready;
	assign emit_go     = (state_q == S_EMIT) && (!out_vld_q || out_ch.ready);
	assign srch_done   = found_q && (inflight_q == '0);
	assign first_free  = tail.pkt.vld && !found_q && !tail.pkt.body.hit;
	assign idx_nx      = CNT_W'(idx_q) + CNT_W'(1);
	assign idx_wide    = {{IOW{1'b0}}, idx_q};
	assign addr_start  = (ent_q.di != '0) ? ent_q.di : ent_q.na;

	always_comb begin
		cmd.load      = acc;
		cmd.clear     = emit_go;
		cmd.advance   = (state_q == S_ADV);
		cmd.entry.na  = in_ch.node_addr;
		cmd.entry.ga  = in_ch.group_addr;
		cmd.entry.di  = in_ch.diag_id;
		cmd.entry.mac = in_ch.mac_addr;
	end

	// packet entering the first cell
	always_comb begin
		inj.vld       = 1'b0;
		inj.body.op   = dar_pkg::OP_FETCH;
		inj.body.hit  = 1'b0;
		inj.body.data = '0;
		unique case (state_q)
			S_FETCH: begin
				inj.vld = 1'b1;
			end
			S_CHKA: begin
				inj.vld       = 1'b1;
				inj.body.op   = dar_pkg::OP_ADDR;
				inj.body.data = EW'(ent_q.na);
			end
			S_CHKM: begin
				inj.vld       = 1'b1;
				inj.body.op   = dar_pkg::OP_MAC;
				inj.body.data = EW'(ent_q.mac);
			end
			S_ASRCH: begin
				inj.vld       = !found_q;
				inj.body.op   = dar_pkg::OP_ADDR;
				inj.body.data = EW'(cand_q[AW-1:0]);
			end
			S_MSRCH: begin
				inj.vld       = !found_q;
				inj.body.op   = dar_pkg::OP_MAC;
				inj.body.data = EW'(cand_q);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		head.filled = 1'b1;
		head.tok    = (idx_q == '0);
		head.pkt    = inj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			count_q    <= '0;
			ovf_q      <= 1'b0;
			idx_q      <= '0;
			found_q    <= 1'b0;
			inflight_q <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			inflight_q <= inflight_q + CNT_W'(inj.vld) - CNT_W'(tail.pkt.vld);
			if (emit_go) begin
				out_vld_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (acc) begin
						if (count_q == CNT_W'(MAX_NODES)) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
						if (in_ch.last_node) begin
							state_q <= S_START;
						end
					end
				end
				S_START: begin
					if (ovf_q || count_q < CNT_W'(dar_pkg::MIN_NODES)) begin
						state_q <= S_EMIT;
					end else begin
						idx_q   <= '0;
						state_q <= S_ADV;
					end
				end
				S_ADV:   state_q <= S_FETCH;
				S_FETCH: state_q <= S_WFETCH;
				S_WFETCH: begin
					if (tail.pkt.vld) begin
						state_q <= S_CHKA;
					end
				end
				S_CHKA:  state_q <= S_CHKM;
				S_CHKM:  state_q <= S_WCHK;
				S_WCHK: begin
					if (tail.pkt.vld && tail.pkt.body.op == dar_pkg::OP_MAC) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					found_q <= 1'b0;
					if (a_hit_q) begin
						state_q <= S_ASRCH;
					end else if (m_hit_q) begin
						state_q <= S_MSRCH;
					end else if (idx_nx == count_q) begin
						state_q <= S_EMIT;
					end else begin
						idx_q   <= idx_nx[IDX_W-1:0];
						state_q <= S_ADV;
					end
				end
				S_ASRCH: begin
					if (first_free) begin
						found_q <= 1'b1;
					end
					if (srch_done) begin
						found_q <= 1'b0;
						state_q <= m_hit_q ? S_MSRCH : S_EMIT;
					end
				end
				S_MSRCH: begin
					if (first_free) begin
						found_q <= 1'b1;
					end
					if (srch_done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						count_q   <= '0;
						ovf_q     <= 1'b0;
						state_q   <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_START: begin
				res_status_q <= ovf_q ? dar_pkg::STAT_OVF : dar_pkg::STAT_FEW;
			end
			S_WFETCH: begin
				if (tail.pkt.vld) begin
					ent_q <= dar_pkg::entry_t'(tail.pkt.body.data);
				end
			end
			S_WCHK: begin
				if (tail.pkt.vld && tail.pkt.body.op == dar_pkg::OP_ADDR) begin
					a_hit_q <= tail.pkt.body.hit;
				end
				if (tail.pkt.vld && tail.pkt.body.op == dar_pkg::OP_MAC) begin
					m_hit_q <= tail.pkt.body.hit && (ent_q.mac != '0);
				end
			end
			S_DEC: begin
				new_na_q     <= dar_pkg::NO_ADDR;
				new_mac_q    <= {1'b0, ent_q.mac};
				res_status_q <= (a_hit_q || m_hit_q) ? dar_pkg::STAT_REPROG : dar_pkg::STAT_OK;
				cand_q       <= a_hit_q ? XW'(addr_start) : ({1'b0, ent_q.mac} + XW'(1));
			end
			S_ASRCH: begin
				if (inj.vld) begin
					cand_q <= XW'(cand_q[AW-1:0] + AW'(1));
				end
				if (first_free) begin
					new_na_q <= tail.pkt.body.data[AW-1:0];
				end
				if (srch_done) begin
					cand_q <= {1'b0, ent_q.mac} + XW'(1);
				end
			end
			S_MSRCH: begin
				if (inj.vld) begin
					cand_q <= cand_q + XW'(1);
				end
				if (first_free) begin
					new_mac_q <= tail.pkt.body.data[XW-1:0];
				end
			end
			default: begin
			end
		endcase

		if (emit_go) begin
			o_status_q <= res_status_q;
			if (res_status_q == dar_pkg::STAT_REPROG) begin
				o_idx_q <= idx_wide[IOW-1:0];
				o_na_q  <= new_na_q;
				o_ga_q  <= ent_q.ga;
				o_mac_q <= new_mac_q[dar_pkg::MAC_W-1:0];
			end else begin
				o_idx_q <= '0;
				o_na_q  <= '0;
				o_ga_q  <= '0;
				o_mac_q <= '0;
			end
		end
	end

	assign out_ch.valid          = out_vld_q;
	assign out_ch.status         = o_status_q;
	assign out_ch.node_index     = o_idx_q;
	assign out_ch.new_node_addr  = o_na_q;
	assign out_ch.new_group_addr = o_ga_q;
	assign out_ch.new_mac_addr   = o_mac_q;

endmodule

`default_nettype wire

### src/duplicate_address_resolver.sv
// top level of the duplicate address resolver: controller plus a chain of node cells
// depends on dar_pkg, dar_if, dar_cell, dar_ctrl and the assertion macro header
//
// usage
//  - in_ch carries one discovered node per item; the item with last_node set closes
//    the set. out_ch carries one result item per set, nothing for the other items.
//  - loading takes one item per cycle: cell k of the chain takes node k of the set.
//    nodes beyond MAX_NODES are dropped and flag a table overflow.
//  - after the closing item, in_ch.ready stays low while the chain is scanned.
//    each node is checked by a fetch pass and a probe pass down the chain; the
//    first clashing node adds one search per clashing field. a set with status
//    2 or 3 reports without a scan.
//  - the pass time is set by the chain length: every packet walks all MAX_NODES
//    cells, one cell per cycle, and candidates follow each other cycle by cycle.
//  - the result sits in an output register; if the receiver stalls, the block waits
//    with the next result but already accepts the items of the next set.
//  - reset empties the chain, the node count and the output register; the table
//    contents themselves are not cleared and are only read once written.
`default_nettype none
`include "duplicate_address_resolver_macros.svh"

module duplicate_address_resolver #(
	parameter int MAX_NODES = dar_pkg::MAX_NODES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	dar_in_if.sink    in_ch,
	dar_out_if.source out_ch
);

	// links[0] comes from the controller, links[k+1] leaves cell k
	dar_pkg::link_t links [0:MAX_NODES];
	dar_pkg::cmd_t  cmd;

	// per-cell views for checking
	logic [MAX_NODES-1:0] tok_vec;
	logic [MAX_NODES-1:0] fill_vec;
	logic [MAX_NODES-1:0] pvld_vec;
	logic                 fill_gap;

	// sequencer: load, scan order, candidate generation and the result register
	dar_ctrl #(
		.MAX_NODES(MAX_NODES)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cmd    (cmd),
		.head   (links[0]),
		.tail   (links[MAX_NODES])
	);

	// chain of cells; each cell compares the passing packet with its own node
	for (genvar k = 0; k < MAX_NODES; k++) begin : g_cell
		dar_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.prev   (links[k]),
			.link   (links[k+1])
		);
		assign tok_vec[k]  = links[k+1].tok;
		assign fill_vec[k] = links[k+1].filled;
		assign pvld_vec[k] = links[k+1].pkt.vld;
	end

	// a filled cell must never follow an empty one
	assign fill_gap = |(fill_vec & ~{fill_vec[MAX_NODES-2:0], 1'b1});

	// at most one cell owns the scan
	`DAR_ASSERT_ALWAYS(a_tok_onehot, $onehot0(tok_vec), "scan token held by several cells")
	// nodes fill the chain from its head without holes
	`DAR_ASSERT_ALWAYS(a_fill_order, !fill_gap, "filled cells are not contiguous")
	// while items are taken, no packet may still walk the chain
	`DAR_ASSERT_IMP(a_idle_chain, in_ch.ready, pvld_vec == '0, "packet in flight while loading")

endmodule

`default_nettype wire
